// ===== rtl/core/nearest_palette_color_unit_assert.svh =====
// Assertion macros for the nearest palette color RTL.
// Included by nearest_palette_color_unit, which checks its own logic; needs nothing else.
`ifndef NEAREST_PALETTE_COLOR_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_UNIT_ASSERT_SVH

// Checked only while reset is released.
`define NPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/npc_pkg.sv =====
// Shared types and constants for the nearest palette color unit.
// Used by npc_cell and nearest_palette_color_unit; depends on nothing.
package npc_pkg;

    localparam int unsigned PALETTE_DEPTH_DEF = 16;
    localparam int unsigned CHAN_W            = 8;
    localparam int unsigned COLOR_W           = 24;
    localparam int unsigned DIST_W            = 18;
    localparam int unsigned ENTRY_W           = 4;
    localparam int unsigned OUT_W             = 4;
    localparam int unsigned ACTIVE_W          = 5;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic {
        CMD_CLASSIFY = 1'b0,
        CMD_WRITE    = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                valid;
        t_cmd                cmd;
        logic [ENTRY_W-1:0]  entry_index;
        logic [COLOR_W-1:0]  color;
        logic [DIST_W-1:0]   run_min;
    } t_beat;

endpackage

// ===== rtl/core/nearest_palette_color_unit.sv =====
// Top level of the nearest palette color unit: a chain of palette cells.
// Depends on npc_pkg, npc_cell and nearest_palette_color_unit_assert.svh.
//
// Input beats carry a command, an entry index and a 24-bit RGB color. A
// classify beat returns the index of the nearest active palette entry by
// squared RGB distance, lowest index on ties; a write beat stores its color
// into one palette entry and returns nothing. Both channels use valid/ready.
// The configuration register active_entries is written through i_cfg_wr_en
// and i_cfg_wr_data; the user must do so only while the unit is idle, which
// the unit does not enforce. Zero acts as one, values above the palette depth as the depth.
// Every beat walks the row of PALETTE_DEPTH cells, one cell per cycle while the
// chain advances; the result comes from the register of the last cell. One
// beat is accepted every cycle while the output is not stalled. A
// write reaches its cell in beat order, so classify beats before it see the
// old entry and those after it the new one.
// When the receiver stalls a pending result, the whole chain holds and the
// input ready drops. Reset clears the palette to zero, sets active_entries to
// 16 and empties the chain.
`include "nearest_palette_color_unit_assert.svh"

module nearest_palette_color_unit #(
    parameter int unsigned PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [npc_pkg::ENTRY_W-1:0]   i_entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]   i_color,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [npc_pkg::OUT_W-1:0]     o_palette_index,
    input  logic                          i_cfg_wr_en,
    input  logic [npc_pkg::ACTIVE_W-1:0]  i_cfg_wr_data
);

    localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
    localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

    logic [npc_pkg::ACTIVE_W-1:0] r_active_entries;
    logic [CNT_W-1:0]             count;
    logic                         advance;
    npc_pkg::t_beat               w_beat [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]             w_idx  [0:PALETTE_DEPTH];
    logic [IDX_W+npc_pkg::OUT_W-1:0] idx_ext;
    npc_pkg::t_beat               last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_entries <= npc_pkg::ACTIVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_active_entries <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_active_entries == '0) begin
            count = CNT_W'(1);
        end else if (32'(r_active_entries) > PALETTE_DEPTH) begin
            count = CNT_W'(PALETTE_DEPTH);
        end else begin
            count = CNT_W'(r_active_entries);
        end
    end

    always_comb begin
        w_beat[0].valid       = i_in_valid;
        w_beat[0].cmd         = npc_pkg::t_cmd'(i_cmd);
        w_beat[0].entry_index = i_entry_index;
        w_beat[0].color       = i_color;
        w_beat[0].run_min     = '0;
        w_idx[0]              = '0;
    end

    genvar k;
    generate
        for (k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
            npc_cell #(
                .DEPTH   (PALETTE_DEPTH),
                .CELL_ID (k)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_advance  (advance),
                .i_count    (count),
                .i_beat     (w_beat[k]),
                .i_best_idx (w_idx[k]),
                .o_beat     (w_beat[k+1]),
                .o_best_idx (w_idx[k+1])
            );
        end
    endgenerate

    assign last_beat       = w_beat[PALETTE_DEPTH];
    assign o_out_valid     = last_beat.valid && (last_beat.cmd == npc_pkg::CMD_CLASSIFY);
    assign advance         = !o_out_valid || i_out_ready;
    assign o_in_ready      = advance;
    assign idx_ext         = {{npc_pkg::OUT_W{1'b0}}, w_idx[PALETTE_DEPTH]};
    assign o_palette_index = idx_ext[npc_pkg::OUT_W-1:0];

    `NPC_ASSERT(a_idx_in_range, i_clk, i_rst_n,
        o_out_valid |-> (32'(w_idx[PALETTE_DEPTH]) < 32'(count)),
        "result index outside the active entries")
    `NPC_ASSERT(a_accept_enters, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> w_beat[1].valid,
        "accepted beat missing from the first cell")
    `NPC_ASSERT(a_stall_holds, i_clk, i_rst_n,
        !advance |=> $stable(w_beat[1]),
        "first cell changed during a stall")
    `NPC_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out_valid,
        "result valid right after reset")

endmodule

// ===== rtl/core/npc_cell.sv =====
// One cell of the palette chain: holds one palette entry, applies writes to it
// and folds its distance into the running minimum. Depends on npc_pkg.
module npc_cell #(
    parameter int unsigned DEPTH   = npc_pkg::PALETTE_DEPTH_DEF,
    parameter int unsigned CELL_ID = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  npc_pkg::t_beat             i_beat,
    input  logic [$clog2(DEPTH)-1:0]   i_best_idx,
    output npc_pkg::t_beat             o_beat,
    output logic [$clog2(DEPTH)-1:0]   o_best_idx
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CW    = npc_pkg::CHAN_W;

    logic [npc_pkg::COLOR_W-1:0] r_entry;
    logic [npc_pkg::COLOR_W-1:0] n_entry;
    npc_pkg::t_beat              r_beat;
    npc_pkg::t_beat              n_beat;
    logic [IDX_W-1:0]            r_best_idx;
    logic [IDX_W-1:0]            n_best_idx;

    logic [CW-1:0]               diff_r;
    logic [CW-1:0]               diff_g;
    logic [CW-1:0]               diff_b;
    logic [npc_pkg::DIST_W-1:0]  sq_sum;
    logic                        active;
    logic                        take;
    logic                        hit;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        diff_r = abs_diff(i_beat.color[3*CW-1:2*CW], r_entry[3*CW-1:2*CW]);
        diff_g = abs_diff(i_beat.color[2*CW-1:CW], r_entry[2*CW-1:CW]);
        diff_b = abs_diff(i_beat.color[CW-1:0], r_entry[CW-1:0]);
        sq_sum = npc_pkg::DIST_W'(diff_r) * npc_pkg::DIST_W'(diff_r)
               + npc_pkg::DIST_W'(diff_g) * npc_pkg::DIST_W'(diff_g)
               + npc_pkg::DIST_W'(diff_b) * npc_pkg::DIST_W'(diff_b);
        active = (32'(i_count) > CELL_ID);
        take   = (CELL_ID == 0) || (active && (sq_sum < i_beat.run_min));
        hit    = i_beat.valid && (i_beat.cmd == npc_pkg::CMD_WRITE)
                 && (32'(i_beat.entry_index) == CELL_ID);
    end

    always_comb begin
        n_beat     = i_beat;
        n_best_idx = i_best_idx;
        n_entry    = r_entry;
        if (i_beat.cmd == npc_pkg::CMD_CLASSIFY && take) begin
            n_beat.run_min = sq_sum;
            n_best_idx     = IDX_W'(CELL_ID);
        end
        if (hit) begin
            n_entry = i_beat.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry    <= '0;
            r_beat     <= '0;
            r_best_idx <= '0;
        end else if (i_advance) begin
            r_entry    <= n_entry;
            r_beat     <= n_beat;
            r_best_idx <= n_best_idx;
        end
    end

    assign o_beat     = r_beat;
    assign o_best_idx = r_best_idx;

endmodule
